// ----- hw/rtl/fdim_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Face dof index map: shared package
// Types, codes, orientation tables and small helper functions for the
// face dof index map unit.
// ----------------------------------------------------------------------------
package fdim_pkg;

    // Highest polynomial order the unit accepts by default.
    localparam int MAX_ORDER_DEFAULT = 15;

    // Polynomial order after reset.
    localparam logic [3:0] POLY_ORDER_RESET = 4'd1;

    // Reciprocal of six for the tetrahedron index, scaled by 2^RECIP_6_SHIFT.
    // Exact for numerators below 2^15.
    localparam int          RECIP_6_SHIFT = 16;
    localparam logic [13:0] RECIP_6       = 14'd10923;

    // Element shape codes.
    localparam logic [1:0] SHAPE_TRI  = 2'd0;
    localparam logic [1:0] SHAPE_QUAD = 2'd1;
    localparam logic [1:0] SHAPE_TET  = 2'd2;
    localparam logic [1:0] SHAPE_HEX  = 2'd3;

    // The identity orientation code leaves a face as it is.
    localparam logic [2:0] ORIENT_IDENTITY = 3'd0;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_ARG = 2'd1,
        ST_OUTSIDE = 2'd2
    } t_status;

    // Source of one reference-frame coordinate under a face orientation.
    typedef enum logic [2:0] {
        SRC_U  = 3'd0,
        SRC_V  = 3'd1,
        SRC_W  = 3'd2,
        SRC_PU = 3'd3,
        SRC_PV = 3'd4
    } t_src;

    // Inverse orientation tables, indexed by orientation code. The last two
    // triangle entries are never used on the good path.
    localparam t_src TRI_A_SRC [8] = '{SRC_U, SRC_W, SRC_W, SRC_U,
                                       SRC_V, SRC_V, SRC_U, SRC_U};
    localparam t_src TRI_B_SRC [8] = '{SRC_V, SRC_V, SRC_U, SRC_W,
                                       SRC_W, SRC_U, SRC_U, SRC_U};
    localparam t_src SQ_A_SRC  [8] = '{SRC_U,  SRC_V,  SRC_V,  SRC_PU,
                                       SRC_PU, SRC_PV, SRC_PV, SRC_U};
    localparam t_src SQ_B_SRC  [8] = '{SRC_V,  SRC_U,  SRC_PU, SRC_V,
                                       SRC_PV, SRC_PU, SRC_U,  SRC_PV};

    // Input item.
    typedef struct packed {
        logic [1:0] elem_shape;
        logic [2:0] side;
        logic [2:0] orientation;
        logic [3:0] face_u;
        logic [3:0] face_v;
    } t_in_item;

    // Result item.
    typedef struct packed {
        logic [11:0] dof_index;
        t_status     status;
    } t_out_item;

    // Number of sides of each shape.
    function automatic logic [2:0] side_count(input logic [1:0] shape);
        logic [2:0] cnt;
        unique case (shape)
            SHAPE_TRI:  cnt = 3'd3;
            SHAPE_QUAD: cnt = 3'd4;
            SHAPE_TET:  cnt = 3'd4;
            SHAPE_HEX:  cnt = 3'd6;
        endcase
        return cnt;
    endfunction

    // Number of orientations of the face type of each shape.
    function automatic logic [3:0] orient_count(input logic [1:0] shape);
        logic [3:0] cnt;
        unique case (shape)
            SHAPE_TRI:  cnt = 4'd2;
            SHAPE_QUAD: cnt = 4'd2;
            SHAPE_TET:  cnt = 4'd6;
            SHAPE_HEX:  cnt = 4'd8;
        endcase
        return cnt;
    endfunction

    // Picks one face coordinate according to a table entry.
    function automatic logic [3:0] src_sel(input t_src src, input logic [3:0] u,
                                           input logic [3:0] v, input logic [3:0] w,
                                           input logic [3:0] p);
        logic [3:0] res;
        unique case (src)
            SRC_U:   res = u;
            SRC_V:   res = v;
            SRC_W:   res = w;
            SRC_PU:  res = p - u;
            SRC_PV:  res = p - v;
            default: res = 4'd0;
        endcase
        return res;
    endfunction

endpackage

// ----- hw/rtl/face_dof_index_map_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Face dof index map unit
// Maps a face-local lattice point on one side of an element, seen under a
// face orientation, to the element-local lexicographic dof index.
// ----------------------------------------------------------------------------
// The unit takes one transfer per clock while the output side does not stall
// and returns one result per transfer, in order. Five register stages carry
// the work: checking and undoing the orientation, embedding into the element,
// the first products of the index formulas, the second product and sums, and
// the multiply by the reciprocal of six that finishes the tetrahedron index.
// A stall on the output holds each full stage in place and input ready falls
// only once every stage is full. The polynomial order is written through
// i_cfg_we and i_cfg_wdata and clamped to MAX_ORDER; the user must write it
// only while no item is in flight, as the block itself does not enforce it.
module face_dof_index_map_unit #(
    parameter int MAX_ORDER = fdim_pkg::MAX_ORDER_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [3:0]          i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  fdim_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output fdim_pkg::t_out_item o_out_data
);

    // Valid bits of the five stages.
    logic r1_valid, r2_valid, r3_valid, r4_valid, r5_valid;

    // Stage advance signals: a stage loads when it is empty or moves on.
    logic adv1, adv2, adv3, adv4, adv5;

    assign adv5 = !r5_valid || i_out_ready;
    assign adv4 = !r4_valid || adv5;
    assign adv3 = !r3_valid || adv4;
    assign adv2 = !r2_valid || adv3;
    assign adv1 = !r1_valid || adv2;

    assign o_in_ready = adv1;

    // Clamped polynomial order register.
    logic [3:0] r_p, n_p;

    always_comb begin
        if (32'(i_cfg_wdata) > MAX_ORDER) begin
            n_p = 4'(MAX_ORDER);
        end else begin
            n_p = i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p <= fdim_pkg::POLY_ORDER_RESET;
        end else if (i_cfg_we) begin
            r_p <= n_p;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: argument checks and inverse orientation.
    // ------------------------------------------------------------------
    logic [1:0]        r1_shape, n1_shape;
    logic [2:0]        r1_side, n1_side;
    fdim_pkg::t_status r1_status, n1_status;
    logic [3:0]        r1_a, n1_a, r1_b, n1_b;
    logic              bad_arg, outside;
    logic [4:0]        sum_uv;
    logic [3:0]        w1;

    always_comb begin
        n1_shape = i_in_data.elem_shape;
        n1_side  = i_in_data.side;
        sum_uv   = {1'b0, i_in_data.face_u} + {1'b0, i_in_data.face_v};
        w1       = r_p - i_in_data.face_u - i_in_data.face_v;
        bad_arg  = (i_in_data.side >= fdim_pkg::side_count(i_in_data.elem_shape)) ||
                   ({1'b0, i_in_data.orientation} >=
                    fdim_pkg::orient_count(i_in_data.elem_shape));
        n1_a     = 4'd0;
        n1_b     = 4'd0;
        outside  = 1'b0;
        unique case (i_in_data.elem_shape)
            fdim_pkg::SHAPE_TRI, fdim_pkg::SHAPE_QUAD: begin
                // Segment face: the identity orientation keeps the direction.
                outside = (i_in_data.face_u > r_p) || (i_in_data.face_v != 4'd0);
                n1_a    = (i_in_data.orientation == fdim_pkg::ORIENT_IDENTITY)
                          ? i_in_data.face_u : r_p - i_in_data.face_u;
            end
            fdim_pkg::SHAPE_TET: begin
                outside = sum_uv > {1'b0, r_p};
                n1_a    = fdim_pkg::src_sel(fdim_pkg::TRI_A_SRC[i_in_data.orientation],
                                            i_in_data.face_u, i_in_data.face_v, w1, r_p);
                n1_b    = fdim_pkg::src_sel(fdim_pkg::TRI_B_SRC[i_in_data.orientation],
                                            i_in_data.face_u, i_in_data.face_v, w1, r_p);
            end
            fdim_pkg::SHAPE_HEX: begin
                outside = (i_in_data.face_u > r_p) || (i_in_data.face_v > r_p);
                n1_a    = fdim_pkg::src_sel(fdim_pkg::SQ_A_SRC[i_in_data.orientation],
                                            i_in_data.face_u, i_in_data.face_v, w1, r_p);
                n1_b    = fdim_pkg::src_sel(fdim_pkg::SQ_B_SRC[i_in_data.orientation],
                                            i_in_data.face_u, i_in_data.face_v, w1, r_p);
            end
        endcase
        // A bad side or orientation takes precedence over the point check.
        priority if (bad_arg) begin
            n1_status = fdim_pkg::ST_BAD_ARG;
        end else if (outside) begin
            n1_status = fdim_pkg::ST_OUTSIDE;
        end else begin
            n1_status = fdim_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (adv1) begin
            r1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r1_shape  <= n1_shape;
            r1_side   <= n1_side;
            r1_status <= n1_status;
            r1_a      <= n1_a;
            r1_b      <= n1_b;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: embed the face point into element coordinates.
    // ------------------------------------------------------------------
    logic [1:0]        r2_shape;
    fdim_pkg::t_status r2_status;
    logic [3:0]        r2_x, n2_x, r2_y, n2_y, r2_z, n2_z;

    always_comb begin
        n2_x = 4'd0;
        n2_y = 4'd0;
        n2_z = 4'd0;
        unique case (r1_shape)
            fdim_pkg::SHAPE_TRI: begin
                unique case (r1_side)
                    3'd0:    begin n2_x = r1_a;       n2_y = 4'd0;        end
                    3'd1:    begin n2_x = r_p - r1_a; n2_y = r1_a;        end
                    default: begin n2_x = 4'd0;       n2_y = r_p - r1_a;  end
                endcase
            end
            fdim_pkg::SHAPE_QUAD: begin
                unique case (r1_side)
                    3'd0:    begin n2_x = r1_a;       n2_y = 4'd0;        end
                    3'd1:    begin n2_x = r_p;        n2_y = r1_a;        end
                    3'd2:    begin n2_x = r_p - r1_a; n2_y = r_p;         end
                    default: begin n2_x = 4'd0;       n2_y = r_p - r1_a;  end
                endcase
            end
            fdim_pkg::SHAPE_TET: begin
                unique case (r1_side)
                    3'd0: begin
                        n2_x = r_p - r1_a - r1_b; n2_y = r1_a; n2_z = r1_b;
                    end
                    3'd1:    begin n2_x = 4'd0; n2_y = r1_b; n2_z = r1_a; end
                    3'd2:    begin n2_x = r1_a; n2_y = 4'd0; n2_z = r1_b; end
                    default: begin n2_x = r1_b; n2_y = r1_a; n2_z = 4'd0; end
                endcase
            end
            fdim_pkg::SHAPE_HEX: begin
                unique case (r1_side)
                    3'd0: begin n2_x = r1_a;       n2_y = r_p - r1_b; n2_z = 4'd0; end
                    3'd1: begin n2_x = r1_a;       n2_y = 4'd0;       n2_z = r1_b; end
                    3'd2: begin n2_x = r_p;        n2_y = r1_a;       n2_z = r1_b; end
                    3'd3: begin n2_x = r_p - r1_a; n2_y = r_p;        n2_z = r1_b; end
                    3'd4: begin n2_x = 4'd0;       n2_y = r_p - r1_a; n2_z = r1_b; end
                    default: begin n2_x = r1_a;    n2_y = r1_b;       n2_z = r_p;  end
                endcase
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (adv2) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r2_shape  <= r1_shape;
            r2_status <= r1_status;
            r2_x      <= n2_x;
            r2_y      <= n2_y;
            r2_z      <= n2_z;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: first products of the index formulas.
    // ------------------------------------------------------------------
    logic [1:0]          r3_shape;
    fdim_pkg::t_status   r3_status;
    logic [3:0]          r3_x, r3_z;
    logic signed [11:0]  r3_m1, n3_m1, r3_m2, n3_m2, r3_c, n3_c;
    logic signed [11:0]  s3_p, s3_y, s3_z;

    assign s3_p = 12'(r_p);
    assign s3_y = 12'(r2_y);
    assign s3_z = 12'(r2_z);

    always_comb begin
        n3_m1 = 12'sd0;
        n3_m2 = 12'sd0;
        n3_c  = 12'sd0;
        unique case (r2_shape)
            fdim_pkg::SHAPE_TRI: begin
                n3_m1 = (12'sd3 + 12'sd2 * s3_p - s3_y) * s3_y;
            end
            fdim_pkg::SHAPE_QUAD: begin
                n3_m1 = (s3_p + 12'sd1) * s3_y;
            end
            fdim_pkg::SHAPE_TET: begin
                n3_m1 = s3_z * (s3_z - 12'sd6 - 12'sd3 * s3_p);
                n3_m2 = s3_y * (s3_y - 12'sd2 * s3_p - 12'sd3);
                n3_c  = 12'sd11 + s3_p * (12'sd12 + 12'sd3 * s3_p) - 12'sd6 * s3_y;
            end
            fdim_pkg::SHAPE_HEX: begin
                n3_m1 = (s3_p + 12'sd1) * s3_z + s3_y;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (adv3) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r3_shape  <= r2_shape;
            r3_status <= r2_status;
            r3_x      <= r2_x;
            r3_z      <= r2_z;
            r3_m1     <= n3_m1;
            r3_m2     <= n3_m2;
            r3_c      <= n3_c;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: second product and sums; tetrahedron numerator.
    // ------------------------------------------------------------------
    logic [1:0]          r4_shape;
    fdim_pkg::t_status   r4_status;
    logic [3:0]          r4_x;
    logic signed [17:0]  r4_val, n4_val;
    logic signed [17:0]  s4_p, s4_x, s4_z, s4_m1, s4_m2, s4_c;

    assign s4_p  = 18'(r_p);
    assign s4_x  = 18'(r3_x);
    assign s4_z  = 18'(r3_z);
    assign s4_m1 = 18'(r3_m1);
    assign s4_m2 = 18'(r3_m2);
    assign s4_c  = 18'(r3_c);

    always_comb begin
        unique case (r3_shape)
            fdim_pkg::SHAPE_TRI:  n4_val = s4_x + (s4_m1 >>> 1);
            fdim_pkg::SHAPE_QUAD: n4_val = s4_m1 + s4_x;
            fdim_pkg::SHAPE_TET:  n4_val = s4_z * (s4_c + s4_m1) - 18'sd3 * s4_m2;
            fdim_pkg::SHAPE_HEX:  n4_val = (s4_p + 18'sd1) * s4_m1 + s4_x;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (adv4) begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv4) begin
            r4_shape  <= r3_shape;
            r4_status <= r3_status;
            r4_x      <= r3_x;
            r4_val    <= n4_val;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: divide the tetrahedron numerator by six and form the result.
    // ------------------------------------------------------------------
    fdim_pkg::t_out_item r5_data, n5_data;
    logic [14:0]         num15;
    logic [28:0]         prod6;
    logic [12:0]         tet_idx;

    always_comb begin
        num15   = r4_val[17] ? 15'd0 : r4_val[14:0];
        prod6   = 29'(num15) * 29'(fdim_pkg::RECIP_6);
        tet_idx = 13'(r4_x) + 13'(prod6 >> fdim_pkg::RECIP_6_SHIFT);
        n5_data.status = r4_status;
        if (r4_status != fdim_pkg::ST_OK) begin
            n5_data.dof_index = 12'd0;
        end else if (r4_shape == fdim_pkg::SHAPE_TET) begin
            n5_data.dof_index = tet_idx[11:0];
        end else begin
            n5_data.dof_index = r4_val[17] ? 12'd0 : r4_val[11:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else if (adv5) begin
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv5) begin
            r5_data <= n5_data;
        end
    end

    assign o_out_valid = r5_valid;
    assign o_out_data  = r5_data;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // An error result always carries a zero index.
    a_err_zero_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != fdim_pkg::ST_OK) |->
            o_out_data.dof_index == 12'd0)
        else $error("error result with non-zero dof index");

    // Input ready falls only when every stage holds an item.
    a_full_before_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r1_valid && r2_valid && r3_valid && r4_valid && r5_valid)
        else $error("input stalled with an empty stage");

    // A stalled stage two keeps its item.
    a_stage2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r2_valid && !adv2 |=> r2_valid && $stable(r2_x) && $stable(r2_y) &&
            $stable(r2_z) && $stable(r2_status))
        else $error("stage two lost its item during a stall");

    // An item in stage four stays when the output stage is blocked.
    a_stage4_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r4_valid && r5_valid && !i_out_ready |=> r4_valid && $stable(r4_val))
        else $error("stage four moved into a blocked output stage");

endmodule
